[src/fbl_pkg.sv]
// ----------------------------------------------------------------------------
// fbl_pkg
// Shared types and constants for the frame buffer layout planner.
// ----------------------------------------------------------------------------
package fbl_pkg;

   // default geometry
   localparam int DOWN_LAYERS_DEF = 24;
   localparam int UP_LAYERS_DEF   = 6;
   localparam int DIM_BITS_DEF    = 13;

   // fixed field widths
   localparam int ADDR_W       = 32;
   localparam int RUN_ADDR_W   = 33;   // running address keeps one carry bit
   localparam int INDEX_W      = 5;
   localparam int FACTOR_W     = 8;
   localparam int LUMA_BYTES_W = 27;
   localparam int CHR_BYTES_W  = 26;
   localparam int COUNT_W      = 5;
   localparam int UPMASK_W     = 6;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 3;
   localparam int ALIGN_BITS   = 4;    // 16-byte alignment

   localparam logic [31:0] SLOT_BYTES_RST = 32'd4194304;

   // request sideband: action in bit 0, layer kind above it
   localparam int REQ_USER_W = 3;
   localparam int RSP_USER_W = 2;

   // response data: index, luma addr, chroma addr, luma bytes, chroma bytes, status
   localparam int RSP_FIELDS_W = INDEX_W + 2 * ADDR_W + LUMA_BYTES_W + CHR_BYTES_W + 2;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_LAYER = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_CROP  = 2'd0,
      KIND_SCALE = 2'd1,
      KIND_DOWN  = 2'd2,
      KIND_UP    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_PLACED   = 2'd0,
      ST_SKIPPED  = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_ABORTED  = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CROP_EN     = 3'd0,
      CSR_SCALE_STORE = 3'd1,
      CSR_PYR_EN      = 3'd2,
      CSR_DOWN_COUNT  = 3'd3,
      CSR_DOWN_SKIP   = 3'd4,
      CSR_UP_MASK     = 3'd5,
      CSR_UP_CHROMA   = 3'd6,
      CSR_SLOT_BYTES  = 3'd7
   } csr_index_type;

endpackage

[src/frame_buffer_layout_planner_unit.sv]
// ----------------------------------------------------------------------------
// frame_buffer_layout_planner_unit
// Places luma and chroma planes of a frame slot in memory, one layer per item.
// ----------------------------------------------------------------------------
// Usage: send a start item (tuser action = start) with the slot base, then one
// item per layer in file order (crop, scale, down layers, up layers). Each
// layer item returns one result item with its plane addresses, sizes and a
// status; start items return nothing. The block takes one item per cycle
// unless a stalled result blocks its input. A result passes through one
// input register, then a single pass of logic (one 14x14-bit width-by-height
// multiply, a 33-bit add chain, realign and limit compare) into the result
// register. The running address, slot limit and overflow flag update in
// that same pass, so consecutive layers chain without bubbles. The input
// register keeps accepting while a result waits on a stalled output,
// holding one item.
// ----------------------------------------------------------------------------
module frame_buffer_layout_planner_unit
   import fbl_pkg::*;
#(
   parameter int DOWN_LAYERS = DOWN_LAYERS_DEF,
   parameter int UP_LAYERS   = UP_LAYERS_DEF,
   parameter int DIM_BITS    = DIM_BITS_DEF,
   localparam int REQ_FIELDS_W = ADDR_W + INDEX_W + 4 * DIM_BITS + FACTOR_W,
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8
)(
   input  logic                   clock,
   input  logic                   reset,
   // request: tdata = base_addr, layer_index, extent_w, extent_h,
   //          origin_w, origin_h, down_factor (low bit up)
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // request tuser = action, layer_kind (low bit up)
   input  logic [REQ_USER_W-1:0]  req_tuser,
   // response: tdata = placed_index, luma_addr, chroma_addr, luma_bytes,
   //           chroma_bytes, status (low bit up)
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // response tuser = placed_kind
   output logic [RSP_USER_W-1:0]  rsp_tuser,
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // request field offsets
   localparam int IDX_LO = ADDR_W;
   localparam int EW_LO  = IDX_LO + INDEX_W;
   localparam int EH_LO  = EW_LO + DIM_BITS;
   localparam int OW_LO  = EH_LO + DIM_BITS;
   localparam int OH_LO  = OW_LO + DIM_BITS;
   localparam int FAC_LO = OH_LO + DIM_BITS;
   localparam int AW     = DIM_BITS + 1;     // aligned dimension
   localparam int PW     = 2 * AW;           // product width
   localparam int RSP_PAD_W = RSP_DATA_W - RSP_FIELDS_W;

   // ---------------- configuration registers ----------------
   logic                    crop_en_ff, scale_on_ff, pyr_en_ff;
   logic [COUNT_W-1:0]      down_count_ff;
   logic [DOWN_LAYERS-1:0]  down_skip_ff;
   logic [UP_LAYERS-1:0]    up_mask_ff, up_chroma_ff;
   logic [ADDR_W-1:0]       slot_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crop_en_ff    <= 1'b0;
         scale_on_ff   <= 1'b0;
         pyr_en_ff     <= 1'b0;
         down_count_ff <= '0;
         down_skip_ff  <= '0;
         up_mask_ff    <= '0;
         up_chroma_ff  <= '0;
         slot_bytes_ff <= SLOT_BYTES_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CROP_EN:     crop_en_ff    <= csr_wdata[0];
            CSR_SCALE_STORE: scale_on_ff   <= csr_wdata[0];
            CSR_PYR_EN:      pyr_en_ff     <= csr_wdata[0];
            CSR_DOWN_COUNT:  down_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_DOWN_SKIP:   down_skip_ff  <= csr_wdata[DOWN_LAYERS-1:0];
            CSR_UP_MASK:     up_mask_ff    <= csr_wdata[UP_LAYERS-1:0];
            CSR_UP_CHROMA:   up_chroma_ff  <= csr_wdata[UP_LAYERS-1:0];
            CSR_SLOT_BYTES:  slot_bytes_ff <= csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                   s1_valid_ff, s1_valid_in;
   action_type             s1_action_ff;
   kind_type               s1_kind_ff;
   logic [ADDR_W-1:0]      s1_base_ff;
   logic [INDEX_W-1:0]     s1_index_ff;
   logic [DIM_BITS-1:0]    s1_ew_ff, s1_eh_ff, s1_ow_ff, s1_oh_ff;
   logic [FACTOR_W-1:0]    s1_factor_ff;

   logic out_valid_ff, out_valid_in;
   logic advance, fire, req_fire;

   // the stage moves on when empty, or when the result slot is free or drains
   assign advance    = !s1_valid_ff || !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign req_fire   = req_tvalid && advance;
   assign fire       = s1_valid_ff && advance;
   assign s1_valid_in = advance ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= action_type'(req_tuser[0]);
         s1_kind_ff   <= kind_type'(req_tuser[2:1]);
         s1_base_ff   <= req_tdata[ADDR_W-1:0];
         s1_index_ff  <= req_tdata[IDX_LO +: INDEX_W];
         s1_ew_ff     <= req_tdata[EW_LO +: DIM_BITS];
         s1_eh_ff     <= req_tdata[EH_LO +: DIM_BITS];
         s1_ow_ff     <= req_tdata[OW_LO +: DIM_BITS];
         s1_oh_ff     <= req_tdata[OH_LO +: DIM_BITS];
         s1_factor_ff <= req_tdata[FAC_LO +: FACTOR_W];
      end
   end

   // ---------------- slot state ----------------
   logic [RUN_ADDR_W-1:0] next_addr_ff, next_addr_in;
   logic [ADDR_W-1:0]     slot_limit_ff, slot_limit_in;
   logic                  overflowed_ff, overflowed_in;

   // ---------------- placement logic ----------------
   logic [DIM_BITS-1:0]   w, h;
   logic [AW-1:0]         w_al, h_al;
   logic [PW-1:0]         prod;
   logic [RUN_ADDR_W-1:0] size, half, chroma_end, end_addr, end_round, base_round;
   logic [DOWN_LAYERS-1:0] skip_sh;
   logic [UP_LAYERS-1:0]   upm_sh, upc_sh;
   logic                  enabled, chroma, ovf_here;
   status_type            status;

   assign skip_sh = down_skip_ff >> s1_index_ff;
   assign upm_sh  = up_mask_ff   >> s1_index_ff;
   assign upc_sh  = up_chroma_ff >> s1_index_ff;

   always_comb begin
      w       = s1_ew_ff;
      h       = s1_eh_ff;
      enabled = 1'b0;
      chroma  = 1'b1;
      case (s1_kind_ff)
         KIND_CROP: begin
            // origin past the end clamps to an empty extent
            w       = (s1_ew_ff > s1_ow_ff) ? (s1_ew_ff - s1_ow_ff) : '0;
            h       = (s1_eh_ff > s1_oh_ff) ? (s1_eh_ff - s1_oh_ff) : '0;
            enabled = crop_en_ff;
         end
         KIND_SCALE: begin
            enabled = scale_on_ff;
         end
         KIND_DOWN: begin
            enabled = pyr_en_ff && (s1_index_ff < down_count_ff)
                   && ({1'b0, s1_index_ff} < (INDEX_W+1)'(DOWN_LAYERS))
                   && !((s1_index_ff != '0) && (s1_factor_ff == '0));
            chroma  = !skip_sh[0];
         end
         KIND_UP: begin
            enabled = pyr_en_ff && ({1'b0, s1_index_ff} < (INDEX_W+1)'(UP_LAYERS))
                   && upm_sh[0];
            chroma  = upc_sh[0];
         end
         default: ;
      endcase
   end

   always_comb begin
      w_al = {1'b0, w} + AW'(15);
      w_al[ALIGN_BITS-1:0] = '0;
      h_al = {1'b0, h} + AW'(15);
      h_al[ALIGN_BITS-1:0] = '0;
   end

   assign prod       = w_al * h_al;
   assign size       = RUN_ADDR_W'(prod);
   assign half       = size >> 1;
   assign chroma_end = next_addr_ff + size;
   assign end_addr   = chroma ? (chroma_end + half) : chroma_end;

   always_comb begin
      end_round = end_addr + RUN_ADDR_W'(15);
      end_round[ALIGN_BITS-1:0] = '0;
      base_round = {1'b0, s1_base_ff} + RUN_ADDR_W'(15);
      base_round[ALIGN_BITS-1:0] = '0;
   end

   assign ovf_here = (end_round >= {1'b0, slot_limit_ff});

   always_comb begin
      if (overflowed_ff) begin
         status = ST_ABORTED;
      end else if (!enabled) begin
         status = ST_SKIPPED;
      end else if (ovf_here) begin
         status = ST_OVERFLOW;
      end else begin
         status = ST_PLACED;
      end
   end

   // state update
   always_comb begin
      next_addr_in  = next_addr_ff;
      slot_limit_in = slot_limit_ff;
      overflowed_in = overflowed_ff;
      if (fire) begin
         if (s1_action_ff == ACT_START) begin
            next_addr_in  = base_round;
            slot_limit_in = s1_base_ff + slot_bytes_ff;
            overflowed_in = 1'b0;
         end else if (!overflowed_ff && enabled) begin
            next_addr_in  = end_round;
            overflowed_in = ovf_here;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_addr_ff  <= '0;
         slot_limit_ff <= '0;
         overflowed_ff <= 1'b0;
      end else begin
         next_addr_ff  <= next_addr_in;
         slot_limit_ff <= slot_limit_in;
         overflowed_ff <= overflowed_in;
      end
   end

   // ---------------- result register ----------------
   logic                    load_out, placed;
   kind_type                out_kind_ff;
   logic [INDEX_W-1:0]      out_index_ff;
   logic [ADDR_W-1:0]       out_luma_addr_ff, out_chroma_addr_ff;
   logic [LUMA_BYTES_W-1:0] out_luma_bytes_ff;
   logic [CHR_BYTES_W-1:0]  out_chroma_bytes_ff;
   status_type              out_status_ff;

   assign load_out = fire && (s1_action_ff == ACT_LAYER);
   assign placed   = !overflowed_ff && enabled;
   assign out_valid_in = load_out ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_kind_ff         <= s1_kind_ff;
         out_index_ff        <= s1_index_ff;
         out_status_ff       <= status;
         out_luma_addr_ff    <= placed ? next_addr_ff[ADDR_W-1:0] : '0;
         out_luma_bytes_ff   <= placed ? size[LUMA_BYTES_W-1:0] : '0;
         out_chroma_addr_ff  <= (placed && chroma) ? chroma_end[ADDR_W-1:0] : '0;
         out_chroma_bytes_ff <= (placed && chroma) ? half[CHR_BYTES_W-1:0] : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_status_ff, out_chroma_bytes_ff,
                        out_luma_bytes_ff, out_chroma_addr_ff, out_luma_addr_ff,
                        out_index_ff};

endmodule

[src/fbl_checker.sv]
// ----------------------------------------------------------------------------
// fbl_checker
// Port-level checks for the frame buffer layout planner, bound to the top.
// ----------------------------------------------------------------------------
module fbl_checker
   import fbl_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEF,
   localparam int REQ_FIELDS_W = ADDR_W + INDEX_W + 4 * DIM_BITS + FACTOR_W,
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8
)(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [REQ_USER_W-1:0] req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int ST_LO = RSP_FIELDS_W - 2;
   localparam int PL_LO = INDEX_W;
   localparam int PL_W  = RSP_FIELDS_W - 2 - INDEX_W;   // addresses and sizes

   logic [1:0]      rsp_status;
   logic [PL_W-1:0] rsp_placement;

   assign rsp_status    = rsp_tdata[ST_LO +: 2];
   assign rsp_placement = rsp_tdata[PL_LO +: PL_W];

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // skipped or aborted layers carry no placement
   a_empty_placement: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == ST_SKIPPED || rsp_status == ST_ABORTED)
      |-> rsp_placement == '0)
      else $error("skipped or aborted item with nonzero placement");

   // a draining output never blocks the input
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input blocked while output drains");

   // a new result follows an accepted item through the input and result registers
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without an accepted item");

endmodule

bind frame_buffer_layout_planner_unit fbl_checker #(
   .DIM_BITS (DIM_BITS)
) u_fbl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
